// ===== src/plqh_pkg.sv =====
// Package for the pitch-lag quantizer: field widths, lag table and sequencer codes.
`timescale 1ns / 1ps

package plqh_pkg;

    // Field widths
    localparam int LAG_W     = 10;
    localparam int CHAN_W    = 3;
    localparam int SHIFT_W   = 3;
    localparam int HYST_W    = 4;
    localparam int TIDX_W    = 6;
    localparam int TABLE_ENTRIES = 64;
    localparam int SEARCH_W  = 5;   // counts the even table entries
    localparam int TERR_W    = 12;  // signed table error incl. hysteresis bonus
    localparam int BASE_W    = 7;   // unclipped base index
    localparam int CIDX_W    = 8;   // signed per-channel table index

    // Configuration register indexes
    localparam logic CFG_HARMONIC_SHIFT = 1'b0;
    localparam logic CFG_LAG_HYSTERESIS = 1'b1;

    // Reset values of the configuration registers
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 3'd2;
    localparam logic [HYST_W-1:0]  HYST_RESET  = 4'd1;

    // Error that a table entry must beat to be chosen
    localparam logic signed [TERR_W-1:0] START_ERROR = 12'sd1024;

    // Sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SUM    = 3'd1;
    localparam logic [2:0] ST_PICK   = 3'd2;
    localparam logic [2:0] ST_SEARCH = 3'd3;
    localparam logic [2:0] ST_BASE   = 3'd4;
    localparam logic [2:0] ST_EMIT   = 3'd5;

    typedef logic [LAG_W-1:0] t_lag;

    // Quantized lag table
    localparam t_lag LAG_ROM [TABLE_ENTRIES] = '{
        10'd14,  10'd15,  10'd16,  10'd17,  10'd18,  10'd19,  10'd20,  10'd22,
        10'd23,  10'd24,  10'd26,  10'd27,  10'd29,  10'd31,  10'd32,  10'd34,
        10'd36,  10'd39,  10'd41,  10'd43,  10'd46,  10'd49,  10'd51,  10'd54,
        10'd58,  10'd61,  10'd65,  10'd69,  10'd73,  10'd77,  10'd82,  10'd86,
        10'd92,  10'd97,  10'd103, 10'd109, 10'd115, 10'd122, 10'd130, 10'd137,
        10'd145, 10'd154, 10'd163, 10'd173, 10'd183, 10'd194, 10'd206, 10'd218,
        10'd231, 10'd245, 10'd259, 10'd275, 10'd291, 10'd308, 10'd327, 10'd346,
        10'd367, 10'd388, 10'd411, 10'd436, 10'd462, 10'd489, 10'd518, 10'd549
    };

endpackage

// ===== src/pitch_lag_quantizer_harmonics.sv =====
// Top level of the pitch-lag quantizer: history, mean pick, table search, channel output.
`timescale 1ns / 1ps

// Each input beat is one frame's pitch lag. It is shifted into a history of
// HISTORY_DEPTH lags; the entry nearest the history mean (oldest on a tie) is
// the representative lag. A voiced representative is matched against every
// second entry of a 64-entry lag table, with a hysteresis bonus for last
// frame's base index, and CHANNELS result beats follow, channel 0 first, each
// carrying the table lag at base - harmonic_shift * channel (zero when
// unvoiced). A small sequencer walks the history twice (sum, then
// nearest-to-mean) and the 32 even table entries once through one add/compare
// unit. An unvoiced frame skips the table search and the base step. The input
// is not ready until the frame's last result sits in the output register; that
// beat may still wait there while the next frame is taken.
module pitch_lag_quantizer_harmonics
    import plqh_pkg::*;
#(
    parameter int HISTORY_DEPTH = 5,
    parameter int CHANNELS      = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_addr,
    input  logic [3:0]  i_cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [9:0] pitch_lag
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [2:0] channel, [12:3] target_lag,
                                        // [22:13] representative_lag
    output logic        m_axis_tuser,   // [0] voiced
    output logic        m_axis_tlast
);

    localparam int SUM_W  = $clog2(HISTORY_DEPTH * 1023 + 1);
    localparam int HIDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int HALF_CH = (CHANNELS - 1) >> 1;
    localparam logic [SUM_W-1:0]  DEPTH_K  = SUM_W'(HISTORY_DEPTH);
    localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(HISTORY_DEPTH - 1);
    localparam logic [CHAN_W-1:0] CH_LAST  = CHAN_W'(CHANNELS - 1);
    localparam logic [BASE_W-1:0] HALF_K   = BASE_W'(HALF_CH);
    localparam logic [BASE_W-1:0] TOP_IDX  = BASE_W'(TABLE_ENTRIES - 1);

    // Control and configuration registers
    logic [2:0]           r_state;
    logic [SHIFT_W-1:0]   r_shift;
    logic [HYST_W-1:0]    r_hyst;
    logic [CNT_W-1:0]     r_cnt;
    logic [SEARCH_W-1:0]  r_k;
    logic [CHAN_W-1:0]    r_chan;
    logic [TIDX_W-1:0]    r_prev_index;
    logic                 r_prev_valid;
    logic                 r_out_valid;

    // Datapath registers
    t_lag                        r_hist [HISTORY_DEPTH];
    logic [SUM_W-1:0]            r_sum;
    logic [SUM_W-1:0]            r_pick_err;
    t_lag                        r_rep;
    logic signed [TERR_W-1:0]    r_best_err;
    logic [SEARCH_W-1:0]         r_best_k;
    logic signed [CIDX_W-1:0]    r_idx;
    logic [CHAN_W-1:0]           r_out_chan;
    t_lag                        r_out_target;
    t_lag                        r_out_rep;
    logic                        r_out_voiced;
    logic                        r_out_last;

    logic                        in_fire;
    logic                        out_load;
    logic                        cnt_done;
    t_lag                        hist_rd;
    logic [SUM_W-1:0]            dx;
    logic [SUM_W-1:0]            pick_err;
    t_lag                        rom_rd;
    logic signed [TERR_W-1:0]    tbl_diff;
    logic signed [TERR_W-1:0]    tbl_err;
    logic [BASE_W-1:0]           base_sum;
    logic [TIDX_W-1:0]           base_clip;
    t_lag                        chan_lag;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign cnt_done      = (r_cnt == CNT_LAST);

    // Shared history read and mean error |sum - DEPTH*x|
    assign hist_rd  = r_hist[r_cnt[HIDX_W-1:0]];
    assign dx       = DEPTH_K * SUM_W'(hist_rd);
    assign pick_err = (r_sum >= dx) ? (r_sum - dx) : (dx - r_sum);

    // Table error of the even entry under test, with hysteresis bonus
    assign rom_rd   = LAG_ROM[{r_k, 1'b0}];
    assign tbl_diff = $signed({2'b00, r_rep}) - $signed({2'b00, rom_rd});
    always_comb begin
        tbl_err = (tbl_diff < 0) ? -tbl_diff : tbl_diff;
        if (r_prev_valid && (r_prev_index == {r_k, 1'b0})) begin
            tbl_err = tbl_err - $signed({{(TERR_W-HYST_W){1'b0}}, r_hyst});
        end
    end

    // Base index (the even table entry), raised by the channel offset and clipped
    assign base_sum  = {1'b0, r_best_k, 1'b0}
                       + HALF_K * {{(BASE_W-SHIFT_W){1'b0}}, r_shift};
    assign base_clip = (base_sum > TOP_IDX) ? TIDX_W'(TOP_IDX) : base_sum[TIDX_W-1:0];

    // Lag of the channel being emitted
    always_comb begin
        if (!(r_rep != '0)) begin
            chan_lag = '0;
        end else if (r_idx < 0) begin
            chan_lag = LAG_ROM[0];
        end else begin
            chan_lag = LAG_ROM[r_idx[TIDX_W-1:0]];
        end
    end

    assign out_load = (r_state == ST_EMIT) && (!r_out_valid || m_axis_tready);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= SHIFT_RESET;
            r_hyst  <= HYST_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                CFG_HARMONIC_SHIFT: r_shift <= i_cfg_data[SHIFT_W-1:0];
                CFG_LAG_HYSTERESIS: r_hyst  <= i_cfg_data[HYST_W-1:0];
                default: ;
            endcase
        end
    end

    // History shift line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                r_hist[i] <= '0;
            end
        end else if (in_fire) begin
            for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
                r_hist[i] <= r_hist[i + 1];
            end
            r_hist[HISTORY_DEPTH - 1] <= s_axis_tdata[LAG_W-1:0];
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cnt        <= '0;
            r_k          <= '0;
            r_chan       <= '0;
            r_prev_index <= '0;
            r_prev_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        r_cnt   <= '0;
                        r_state <= ST_SUM;
                    end
                end
                ST_SUM: begin
                    r_cnt <= cnt_done ? '0 : r_cnt + 1'b1;
                    if (cnt_done) begin
                        r_state <= ST_PICK;
                    end
                end
                ST_PICK: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (cnt_done) begin
                        r_k <= '0;
                        r_chan <= '0;
                        // forget the previous choice on an unvoiced frame
                        if (((pick_err < r_pick_err) || (r_cnt == '0)) ? (hist_rd == '0)
                                                                      : (r_rep == '0)) begin
                            r_prev_index <= '0;
                            r_prev_valid <= 1'b0;
                            r_state      <= ST_EMIT;
                        end else begin
                            r_state <= ST_SEARCH;
                        end
                    end
                end
                ST_SEARCH: begin
                    r_k <= r_k + 1'b1;
                    if (r_k == '1) begin
                        r_state <= ST_BASE;
                    end
                end
                ST_BASE: begin
                    r_prev_index <= base_clip;
                    r_prev_valid <= 1'b1;
                    r_state      <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (out_load) begin
                        r_chan <= r_chan + 1'b1;
                        if (r_chan == CH_LAST) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Datapath: sum, nearest-to-mean pick, table search, channel index walk
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_sum <= '0;
            end
            ST_SUM: begin
                r_sum <= r_sum + SUM_W'(hist_rd);
            end
            ST_PICK: begin
                // strict compare keeps the oldest entry on a tie
                if ((r_cnt == '0) || (pick_err < r_pick_err)) begin
                    r_pick_err <= pick_err;
                    r_rep      <= hist_rd;
                end
                r_best_err <= START_ERROR;
                r_best_k   <= '0;
            end
            ST_SEARCH: begin
                if (tbl_err < r_best_err) begin
                    r_best_err <= tbl_err;
                    r_best_k   <= r_k;
                end
            end
            ST_BASE: begin
                r_idx <= $signed({2'b00, base_clip});
            end
            ST_EMIT: begin
                if (out_load) begin
                    r_idx <= r_idx - $signed({{(CIDX_W-SHIFT_W){1'b0}}, r_shift});
                end
            end
            default: ;
        endcase
    end

    // Output register: hold a beat until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_chan   <= r_chan;
            r_out_target <= chan_lag;
            r_out_rep    <= r_rep;
            r_out_voiced <= (r_rep != '0);
            r_out_last   <= (r_chan == CH_LAST);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_rep, r_out_target, r_out_chan};
    assign m_axis_tuser  = r_out_voiced;
    assign m_axis_tlast  = r_out_last;

    // The last flag marks exactly the final channel
    a_last_chan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[2:0] == CH_LAST)))
        else $error("tlast does not match the final channel");

    // Unvoiced beats carry a zero lag and a zero representative
    a_unvoiced_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> ((m_axis_tdata[12:3] == '0)
                                              && (m_axis_tdata[22:13] == '0)))
        else $error("unvoiced beat carries a nonzero lag");

    // A forgotten choice leaves the stored index at zero
    a_prev_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_prev_valid |-> (r_prev_index == '0))
        else $error("stored index kept without a valid choice");

    // An accepted frame starts the history sum
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == ST_SUM))
        else $error("accepted frame did not start the sequencer");

    // A new beat is loaded only when the output register is free or drained
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> ($stable(m_axis_tdata) && m_axis_tvalid))
        else $error("pending output beat was overwritten");

endmodule

// ===== bench/plqh_checker.sv =====
// Checker for the pitch-lag quantizer: watches the streams, predicts channel beats, compares.
`timescale 1ns / 1ps

module plqh_checker
    import plqh_pkg::*;
#(
    parameter int HISTORY_DEPTH = 5,
    parameter int CHANNELS      = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_addr,
    input  logic [3:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,
    input  logic        m_axis_tuser,
    input  logic        m_axis_tlast,
    output int          o_mismatches,
    output int          o_pending,
    output int          o_beats_checked
);

    localparam int SEARCH_STEP = 2;

    typedef struct packed {
        logic [CHAN_W-1:0] channel;
        t_lag              target;
        t_lag              rep;
        logic              voiced;
        logic              last;
    } t_chan_beat;

    t_chan_beat expected_beats[$];

    // Mirror of the block's state and registers
    t_lag               lag_history [HISTORY_DEPTH];
    logic [TIDX_W-1:0]  prev_index;
    logic               prev_valid;
    logic [SHIFT_W-1:0] harmonic_shift;
    logic [HYST_W-1:0]  lag_hysteresis;

    int mismatches    = 0;
    int beats_checked = 0;
    int pending_count = 0;

    assign o_mismatches    = mismatches;
    assign o_pending       = pending_count;
    assign o_beats_checked = beats_checked;

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("%0t ns: %s expected %0d got %0d", $time, what, want, got);
        mismatches++;
    endtask

    // Pick the history entry nearest the mean; oldest wins a tie
    function automatic t_lag nearest_to_mean();
        int   total;
        int   err;
        int   best_err;
        t_lag pick;
        total    = 0;
        best_err = 32'h7fff_ffff;
        pick     = '0;
        foreach (lag_history[i]) total += int'(lag_history[i]);
        foreach (lag_history[i]) begin
            err = total - HISTORY_DEPTH * int'(lag_history[i]);
            if (err < 0) err = -err;
            if (err < best_err) begin
                best_err = err;
                pick     = lag_history[i];
            end
        end
        return pick;
    endfunction

    // Search the even table entries, with the bonus on last frame's base index
    function automatic int search_lag_table(input t_lag rep);
        int err;
        int best_err;
        int best;
        best_err = int'(START_ERROR);
        best     = 0;
        for (int k = 0; k < TABLE_ENTRIES; k += SEARCH_STEP) begin
            err = int'(rep) - int'(LAG_ROM[k]);
            if (err < 0) err = -err;
            if (prev_valid && int'(prev_index) == k) err -= int'(lag_hysteresis);
            if (err < best_err) begin
                best_err = err;
                best     = k;
            end
        end
        return best;
    endfunction

    // Advance the history by one frame and queue its channel beats
    task automatic quantize_frame(input t_lag lag);
        t_lag       rep;
        logic       voiced;
        int         base;
        int         idx;
        t_chan_beat beat;
        for (int i = 0; i + 1 < HISTORY_DEPTH; i++) lag_history[i] = lag_history[i + 1];
        lag_history[HISTORY_DEPTH - 1] = lag;
        rep    = nearest_to_mean();
        voiced = (rep != '0);
        base   = 0;
        if (voiced) begin
            base = search_lag_table(rep) + ((CHANNELS - 1) >> 1) * int'(harmonic_shift);
            if (base > TABLE_ENTRIES - 1) base = TABLE_ENTRIES - 1;
            prev_index = TIDX_W'(base);
            prev_valid = 1'b1;
        end else begin
            prev_index = '0;
            prev_valid = 1'b0;
        end
        for (int c = 0; c < CHANNELS; c++) begin
            beat.channel = CHAN_W'(c);
            beat.target  = '0;
            if (voiced) begin
                idx         = base - int'(harmonic_shift) * c;
                beat.target = (idx < 0) ? LAG_ROM[0] : LAG_ROM[idx];
            end
            beat.rep    = rep;
            beat.voiced = voiced;
            beat.last   = (c == CHANNELS - 1);
            expected_beats.push_back(beat);
        end
    endtask

    // Compare one output beat against the oldest expectation
    task automatic check_beat();
        t_chan_beat want;
        if (expected_beats.size() == 0) begin
            report_mismatch("channel beat with no frame pending, channel",
                            -1, int'(m_axis_tdata[2:0]));
        end else begin
            want = expected_beats.pop_front();
            if (m_axis_tdata[2:0] != want.channel)
                report_mismatch("channel", int'(want.channel), int'(m_axis_tdata[2:0]));
            if (m_axis_tdata[12:3] != want.target)
                report_mismatch("target_lag", int'(want.target), int'(m_axis_tdata[12:3]));
            if (m_axis_tdata[22:13] != want.rep)
                report_mismatch("representative_lag", int'(want.rep),
                                int'(m_axis_tdata[22:13]));
            if (m_axis_tuser !== want.voiced)
                report_mismatch("voiced", int'(want.voiced), int'(m_axis_tuser));
            if (m_axis_tlast !== want.last)
                report_mismatch("last", int'(want.last), int'(m_axis_tlast));
        end
        beats_checked++;
    endtask

    // Sample all channels at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (lag_history[i]) lag_history[i] = '0;
            prev_index     = '0;
            prev_valid     = 1'b0;
            harmonic_shift = SHIFT_RESET;
            lag_hysteresis = HYST_RESET;
            expected_beats.delete();
            pending_count <= 0;
        end else begin
            if (i_cfg_wr_en) begin
                if (i_cfg_addr == CFG_HARMONIC_SHIFT) harmonic_shift = i_cfg_data[SHIFT_W-1:0];
                else                                  lag_hysteresis = i_cfg_data[HYST_W-1:0];
            end
            if (s_axis_tvalid && s_axis_tready) quantize_frame(s_axis_tdata[LAG_W-1:0]);
            if (m_axis_tvalid && m_axis_tready) check_beat();
            pending_count <= expected_beats.size();
        end
    end

endmodule

// ===== bench/pitch_lag_quantizer_harmonics_tb.sv =====
// Testbench top for the pitch-lag quantizer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module pitch_lag_quantizer_harmonics_tb
    import plqh_pkg::*;
();

    localparam int HISTORY_DEPTH = 5;
    localparam int CHANNELS      = 3;
    localparam int PHASES        = 7;
    localparam int RANDOM_FRAMES = 43;
    localparam int DRAIN_CYCLES  = 60;

    // Register settings per phase: range ends, out-of-range shifts, bonus extremes
    localparam logic [SHIFT_W-1:0] SHIFT_SET [PHASES] = '{3'd2, 3'd4, 3'd3, 3'd0, 3'd7, 3'd2, 3'd4};
    localparam logic [HYST_W-1:0]  HYST_SET  [PHASES] = '{4'd1, 4'd0, 4'd15, 4'd7, 4'd15, 4'd0, 4'd15};

    // Directed frames: full-scale lags, zero runs, a mean tie, a table boundary,
    // lags around a search midpoint and the smallest voiced lag
    localparam t_lag FRAME_LAGS [24] = '{
        10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023,
        10'd0,    10'd0,    10'd0,
        10'd10,   10'd30,   10'd12,   10'd33,   10'd15,
        10'd41,   10'd43,   10'd44,   10'd46,   10'd44,   10'd43,
        10'd549,  10'd512,  10'd1,    10'd1,    10'd1
    };

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic        i_cfg_addr    = 1'b0;
    logic [3:0]  i_cfg_data    = '0;
    logic        s_axis_tvalid = 1'b0;
    logic [15:0] s_axis_tdata  = '0;    // [9:0] pitch_lag
    logic        m_axis_tready = 1'b0;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [23:0] m_axis_tdata;          // [2:0] channel, [12:3] target_lag,
                                        // [22:13] representative_lag
    logic        m_axis_tuser;          // [0] voiced
    logic        m_axis_tlast;

    logic quiet   = 1'b0;
    int   rx_hold = 0;
    int   mismatches;
    int   pending;
    int   beats_checked;
    int   frames_sent = 0;

    always #2 i_clk = ~i_clk;

    pitch_lag_quantizer_harmonics #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .CHANNELS      (CHANNELS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    plqh_checker #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .CHANNELS      (CHANNELS)
    ) plqh_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .m_axis_tlast    (m_axis_tlast),
        .o_mismatches    (mismatches),
        .o_pending       (pending),
        .o_beats_checked (beats_checked)
    );

    // Stall the result side by a random draw after each beat, never when quiet
    always @(posedge i_clk) begin : rx_side
        int draw;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_hold       <= 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            draw = quiet ? 0 : int'($urandom_range(0, 3));
            rx_hold       <= draw;
            m_axis_tready <= (draw == 0);
        end else if (rx_hold > 0) begin
            rx_hold       <= rx_hold - 1;
            m_axis_tready <= (rx_hold == 1);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Write both registers on back-to-back edges
    task automatic set_config(input logic [SHIFT_W-1:0] shift, input logic [HYST_W-1:0] hyst);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= CFG_HARMONIC_SHIFT;
        i_cfg_data  <= 4'(shift);
        @(posedge i_clk);
        i_cfg_addr  <= CFG_LAG_HYSTERESIS;
        i_cfg_data  <= hyst;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Offer one frame after a random gap and hold it until the beat is taken
    task automatic send_lag(input t_lag lag);
        int gap;
        gap = quiet ? 0 : int'($urandom_range(0, 3));
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, lag};
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        frames_sent++;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        int   center;
        int   roll;
        int   zero_left;
        t_lag lag;
        center    = 200;
        zero_left = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < PHASES; phase++) begin
            quiet <= (phase == 2 || phase == 5);
            set_config(SHIFT_SET[phase], HYST_SET[phase]);
            if (phase == 0) begin
                foreach (FRAME_LAGS[i]) send_lag(FRAME_LAGS[i]);
            end
            // Mostly slow drift around a center, with unvoiced runs, jumps and noise
            repeat (RANDOM_FRAMES) begin
                roll = $urandom_range(0, 99);
                if (zero_left > 0) begin
                    lag = '0;
                    zero_left--;
                end else if (roll < 60) begin
                    center += int'($urandom_range(0, 12)) - 6;
                    if (center < 14)  center = 14;
                    if (center > 600) center = 600;
                    lag = LAG_W'(center);
                end else if (roll < 72) begin
                    lag       = '0;
                    zero_left = $urandom_range(1, 4);
                end else if (roll < 87) begin
                    lag = LAG_W'($urandom_range(0, 1023));
                end else begin
                    center = $urandom_range(14, 560);
                    lag    = LAG_W'(center);
                end
                send_lag(lag);
            end
            s_axis_tvalid <= 1'b0;
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d frames over %0d register settings (shift 0..7, hysteresis 0..15),",
                 frames_sent, PHASES);
        $display("checked %0d channel beats, %0d mismatches", beats_checked, mismatches);
        if (mismatches == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
src/plqh_pkg.sv
src/pitch_lag_quantizer_harmonics.sv
bench/plqh_checker.sv
bench/pitch_lag_quantizer_harmonics_tb.sv
